FILE: hw/rtl/per_client_fixed_window_rate_limiter_top_macros.svh
`ifndef PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_TOP_MACROS_SVH
`define PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PCFWRL_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcfwrl: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define PCFWRL_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcfwrl: next-cycle check failed");

`endif

FILE: hw/rtl/pcfwrl_pkg.sv
`default_nettype none

package pcfwrl_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam logic [15:0] MAX_REQ_RESET = 16'd10;

	localparam logic [2:0] OUT_COUNTED    = 3'd0;
	localparam logic [2:0] OUT_NEW_WINDOW = 3'd1;
	localparam logic [2:0] OUT_NEW_CLIENT = 3'd2;
	localparam logic [2:0] OUT_UNTRACKED  = 3'd3;
	localparam logic [2:0] OUT_DENIED     = 3'd4;

	// register addressing: byte address bit 2 selects the register word
	localparam int PADDR_W = 3;
	localparam logic REG_WINDOW_CAP = 1'b0;

	typedef struct packed {
		logic [31:0] client_key;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic       allowed;
		logic [2:0] outcome;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic update;
		logic insert;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pcfwrl_ctrl.sv
`default_nettype none

module pcfwrl_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  pcfwrl_pkg::dp_sts_t  sts,
	output pcfwrl_pkg::dp_cmd_t  cmd
);
	import pcfwrl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.start = start;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// a hit wins over the end of the used entries
				priority if (sts.hit) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.last) begin
					cmd.insert = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pcfwrl_dp.sv
`default_nettype none

module pcfwrl_dp #(
	parameter int TABLE_DEPTH = pcfwrl_pkg::TABLE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pcfwrl_pkg::dp_cmd_t  cmd,
	output pcfwrl_pkg::dp_sts_t  sts,
	input  pcfwrl_pkg::req_t     req,
	input  wire [15:0]           window_cap,
	output logic                 done,
	output pcfwrl_pkg::rsp_t     rsp
);
	import pcfwrl_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [31:0] key_mem   [TABLE_DEPTH];
	logic [15:0] cnt_mem   [TABLE_DEPTH];
	logic [31:0] start_mem [TABLE_DEPTH];

	req_t             req_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] used_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_vld_q;
	logic             rd_end_q;
	logic [31:0]      key_rd_q;
	logic [15:0]      cnt_rd_q;
	logic [31:0]      start_rd_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             in_range;
	logic             rd_en;
	logic [31:0]      diff;
	logic             new_win;
	logic             deny;
	logic             full;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [15:0]      wr_cnt;
	logic [31:0]      wr_start;
	logic             used_inc;
	rsp_t             rsp_d;

	assign in_range = (scan_idx_q < used_q);
	assign rd_en    = cmd.scan && in_range;

	assign sts.hit  = rd_vld_q && (key_rd_q == req_q.client_key);
	assign sts.last = rd_end_q;

	assign diff    = req_q.now_seconds - start_rd_q;
	assign new_win = (diff != 32'd0) && !diff[31];
	assign deny    = (cnt_rd_q >= window_cap);
	assign full    = (used_q == CNT_W'(TABLE_DEPTH));

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = rd_idx_q;
		wr_cnt   = 16'd1;
		wr_start = req_q.now_seconds;
		used_inc = 1'b0;
		rsp_d    = '0;
		if (cmd.update) begin
			priority if (new_win) begin
				wr_en         = 1'b1;
				rsp_d.allowed = 1'b1;
				rsp_d.outcome = OUT_NEW_WINDOW;
			end else if (deny) begin
				rsp_d.allowed = 1'b0;
				rsp_d.outcome = OUT_DENIED;
			end else begin
				wr_en         = 1'b1;
				wr_cnt        = cnt_rd_q + 16'd1;
				wr_start      = start_rd_q;
				rsp_d.allowed = 1'b1;
				rsp_d.outcome = OUT_COUNTED;
			end
		end else if (cmd.insert) begin
			wr_idx        = used_q[IDX_W-1:0];
			rsp_d.allowed = 1'b1;
			if (full) begin
				rsp_d.outcome = OUT_UNTRACKED;
			end else begin
				wr_en         = 1'b1;
				used_inc      = 1'b1;
				rsp_d.outcome = OUT_NEW_CLIENT;
			end
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx]   <= req_q.client_key;
			cnt_mem[wr_idx]   <= wr_cnt;
			start_mem[wr_idx] <= wr_start;
		end
		if (rd_en) begin
			key_rd_q   <= key_mem[scan_idx_q[IDX_W-1:0]];
			cnt_rd_q   <= cnt_mem[scan_idx_q[IDX_W-1:0]];
			start_rd_q <= start_mem[scan_idx_q[IDX_W-1:0]];
			rd_idx_q   <= scan_idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
		if (cmd.update || cmd.insert) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			used_q     <= '0;
			rd_vld_q   <= 1'b0;
			rd_end_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.update || cmd.insert;
			if (cmd.start) begin
				scan_idx_q <= '0;
				rd_vld_q   <= 1'b0;
				rd_end_q   <= 1'b0;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
				rd_vld_q   <= in_range;
				rd_end_q   <= !in_range;
			end
			if (used_inc) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/per_client_fixed_window_rate_limiter_top.sv
`default_nettype none

// Per-client fixed-window rate limiter. Pulse start with a request (client key and time in
// seconds) while busy is low; the block scans its used table entries in order, one entry a
// cycle through the single read port of the table memory, and then updates or enters the
// client. The result appears on rsp with done high for exactly one cycle after busy falls.
// The receiver cannot stall: take rsp in the cycle done is high; rsp holds until the next
// result. A new request may start in the cycle done is shown. The table needs no clearing
// after reset, since only entries below the used count are ever read. The window cap (most
// requests per client per second) sits at byte address 0 of the APB port and should be
// written only while busy is low.
module per_client_fixed_window_rate_limiter_top #(
	parameter int TABLE_DEPTH = pcfwrl_pkg::TABLE_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  pcfwrl_pkg::req_t                   req,
	output logic                               done,
	output pcfwrl_pkg::rsp_t                   rsp,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire [pcfwrl_pkg::PADDR_W-1:0]      paddr,
	input  wire [31:0]                         pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import pcfwrl_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [15:0] window_cap_q;
	logic        reg_sel;

	assign reg_sel = (paddr[2] == REG_WINDOW_CAP);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {16'd0, window_cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_cap_q <= MAX_REQ_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			window_cap_q <= pwdata[15:0];
		end
	end

	pcfwrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pcfwrl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req        (req),
		.window_cap (window_cap_q),
		.done       (done),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/pcfwrl_checker.sv
`default_nettype none

`include "per_client_fixed_window_rate_limiter_top_macros.svh"

module pcfwrl_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                start,
	input wire                busy,
	input wire                done,
	input pcfwrl_pkg::rsp_t   rsp
);
	import pcfwrl_pkg::*;

	// a beat passes exactly when it was not denied
	`PCFWRL_ASSERT_SAME(a_allow_code, clk, arst_n, done, rsp.allowed ^ (rsp.outcome == OUT_DENIED))

	`PCFWRL_ASSERT_SAME(a_outcome_known, clk, arst_n, done, rsp.outcome <= OUT_DENIED)

	// an accepted request keeps the block busy until it resolves
	`PCFWRL_ASSERT_NEXT(a_start_sets_busy, clk, arst_n, start && !busy, busy)

	// a result only follows a scan that just ended
	`PCFWRL_ASSERT_SAME(a_done_after_busy, clk, arst_n, done, $past(busy) && !$past(done))

endmodule

bind per_client_fixed_window_rate_limiter_top pcfwrl_checker u_pcfwrl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire

FILE: tb/tb_per_client_fixed_window_rate_limiter_top.sv
`timescale 1ns / 100ps

module tb_per_client_fixed_window_rate_limiter_top;
	import pcfwrl_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [PADDR_W-1:0] ADDR_WINDOW_CAP = {REG_WINDOW_CAP, 2'b00};

	// Tracks client windows and holds the verdicts still owed by the block.
	class limiter_scoreboard;
		logic [31:0] key_tab [DEPTH];
		logic [15:0] count_tab [DEPTH];
		logic [31:0] window_tab [DEPTH];
		int unsigned entries_used = 0;
		logic [15:0] req_limit = MAX_REQ_RESET;
		rsp_t pending_verdicts [$];
		int failures = 0;
		int seen [5];

		function void set_limit(logic [15:0] v);
			req_limit = v;
		endfunction

		function void note_request(req_t r);
			rsp_t v;
			logic [31:0] age;
			int unsigned i;
			bit found;
			found = 1'b0;
			for (i = 0; i < entries_used; i++) begin
				if (key_tab[i] == r.client_key) begin
					found = 1'b1;
					break;
				end
			end
			if (found) begin
				// signed age of at least one second opens a fresh window
				age = r.now_seconds - window_tab[i];
				if (age != 32'd0 && !age[31]) begin
					count_tab[i] = 16'd1;
					window_tab[i] = r.now_seconds;
					v.allowed = 1'b1;
					v.outcome = OUT_NEW_WINDOW;
				end else if (count_tab[i] >= req_limit) begin
					v.allowed = 1'b0;
					v.outcome = OUT_DENIED;
				end else begin
					count_tab[i] = count_tab[i] + 16'd1;
					v.allowed = 1'b1;
					v.outcome = OUT_COUNTED;
				end
			end else if (entries_used < DEPTH) begin
				key_tab[entries_used] = r.client_key;
				count_tab[entries_used] = 16'd1;
				window_tab[entries_used] = r.now_seconds;
				entries_used++;
				v.allowed = 1'b1;
				v.outcome = OUT_NEW_CLIENT;
			end else begin
				v.allowed = 1'b1;
				v.outcome = OUT_UNTRACKED;
			end
			pending_verdicts.push_back(v);
		endfunction

		function void check_verdict(rsp_t got);
			rsp_t want;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected verdict beat: allowed %0d outcome %0d",
					got.allowed, got.outcome);
				failures++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.allowed !== want.allowed) begin
				$error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
				failures++;
			end
			if (got.outcome !== want.outcome) begin
				$error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
				failures++;
			end
			if (want.outcome <= OUT_DENIED)
				seen[want.outcome]++;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	limiter_scoreboard ledger = new;
	logic [31:0] known_keys [$];
	logic [31:0] now_s;
	int requests_sent = 0;
	logic [15:0] rand_limit;

	per_client_fixed_window_rate_limiter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			ledger.check_verdict(rsp);
	end

	// Hold start high until the block takes the beat.
	task automatic send_request(logic [31:0] key, logic [31:0] sec);
		req_t r;
		r.client_key = key;
		r.now_seconds = sec;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		ledger.note_request(r);
		requests_sent++;
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0 || busy !== 1'b0);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_xfer(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_WINDOW_CAP;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		logic [31:0] rd;
		drain();
		apb_xfer(1'b1, {16'h0000, v}, rd);
		ledger.set_limit(v);
		apb_xfer(1'b0, 32'h0, rd);
		if (rd[15:0] !== v) begin
			$error("window_cap: expected %0d, got %0d", v, rd[15:0]);
			ledger.failures++;
		end
	endtask

	task automatic run_random(int n, bit steady, bit mid_drain);
		int i;
		int pick;
		int step;
		int back;
		logic [31:0] key;
		for (i = 0; i < n; i++) begin
			if (!steady && $urandom_range(0, 99) < 26) begin
				if ($urandom_range(0, 7) == 0)
					pause_sender($urandom_range(9, 300));
				else
					pause_sender($urandom_range(1, 8));
			end
			if (mid_drain && i == n / 2)
				drain();
			// advance time mostly by nothing or a second, now and then jump or go back
			step = $urandom_range(0, 99);
			if (step >= 70 && step < 85)
				now_s = now_s + 32'd1;
			else if (step >= 85 && step < 90)
				now_s = now_s + $urandom_range(2, 5);
			else if (step >= 90 && step < 95)
				now_s = now_s - $urandom_range(1, 3);
			else if (step >= 95)
				now_s = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				key = $urandom;
				known_keys.push_back(key);
			end else if (pick < 90) begin
				back = $urandom_range(0, (known_keys.size() > 6) ? 5 : known_keys.size() - 1);
				key = known_keys[known_keys.size() - 1 - back];
			end else begin
				key = known_keys[$urandom_range(0, known_keys.size() - 1)];
			end
			send_request(key, now_s);
		end
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		now_s = 32'd0;
		known_keys.push_back(32'h0000_0000);
		known_keys.push_back(32'hFFFF_FFFF);
		known_keys.push_back(32'h5A5A_5A5A);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit of ten: fill one window, then deny
		for (k = 0; k < 11; k++)
			send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// time wraps to zero: new window
		send_request(32'hFFFF_FFFF, 32'h0000_0000);
		// time steps back: same window
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'h0000_0000, 32'h8000_0000);
		send_request(32'h0000_0000, 32'h7FFF_FFFF);

		// zero limit: new clients and new windows still pass
		write_limit(16'd0);
		send_request(32'h5A5A_5A5A, 32'd100);
		send_request(32'h5A5A_5A5A, 32'd100);
		send_request(32'h5A5A_5A5A, 32'd101);
		send_request(32'h5A5A_5A5A, 32'd101);

		now_s = $urandom;
		write_limit(16'd3);
		run_random(116, 1'b0, 1'b1);
		write_limit(16'hFFFF);
		run_random(116, 1'b1, 1'b0);
		write_limit(16'd1);
		run_random(116, 1'b0, 1'b0);
		rand_limit = 16'($urandom_range(0, 65535));
		write_limit(rand_limit);
		run_random(116, 1'b0, 1'b0);
		write_limit(16'd2);
		run_random(116, 1'b0, 1'b0);

		drain();
		repeat (DEPTH + 8) @(posedge clk);
		$display("Sent %0d requests under limits 10, 0, 3, 65535, 1, %0d and 2; %0d entries used",
			requests_sent, rand_limit, ledger.entries_used);
		$display("Verdicts: counted %0d, new window %0d, new client %0d, untracked %0d, denied %0d",
			ledger.seen[OUT_COUNTED], ledger.seen[OUT_NEW_WINDOW], ledger.seen[OUT_NEW_CLIENT],
			ledger.seen[OUT_UNTRACKED], ledger.seen[OUT_DENIED]);
		if (ledger.failures == 0 && ledger.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
